// File: hdl/pts_pkg.sv
// shared types, codes and helpers for the priority task scheduler
// no dependencies; used by pts_sweep and priority_task_scheduler
package pts_pkg;

  localparam int PRIO_W           = 6;
  localparam int NUM_PRIO         = 64;
  localparam int SLOT_W           = 7;
  localparam int ISR_W            = 8;
  localparam int TICK_W           = 32;
  localparam int LOWEST_PRIO_DEF  = 63;
  localparam int TASK_SLOTS_DEF   = 16;

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_DELAY     = 3'd1,
    OP_TICK      = 3'd2,
    OP_ISR_ENTER = 3'd3,
    OP_ISR_EXIT  = 3'd4,
    OP_SCHEDULE  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_PRIO = 3'd1,
    ST_TAKEN    = 3'd2,
    ST_IN_ISR   = 3'd3,
    ST_NO_SLOT  = 3'd4,
    ST_IGNORED  = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]        operation;
    logic [PRIO_W-1:0] priority_req;
    logic [TICK_W-1:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              switch_request;
    logic [PRIO_W-1:0] next_priority;
    logic [TICK_W-1:0] tick_count;
  } out_item_t;

  // command from the sequencer to the delay counter sweep unit
  typedef struct packed {
    logic              load;
    logic              start;
    logic [PRIO_W-1:0] addr;
    logic [TICK_W-1:0] value;
  } sweep_cmd_t;

  // per-entry report from the sweep unit
  typedef struct packed {
    logic              expired;
    logic [PRIO_W-1:0] idx;
    logic              done;
  } sweep_rpt_t;

  function automatic logic [2:0] low_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

// File: hdl/priority_task_scheduler.sv
// top level of the priority task scheduler: sequencer, ready bitmap and config register
// depends on pts_pkg and pts_sweep
//
//   port group   direction   handshake            payload
//   in           in          in_valid_i/stall_o   in_data_i  (pts_pkg::in_item_t)
//   out          out         out_valid_o/stall_i  out_data_o (pts_pkg::out_item_t)
//   apb          in/out      psel/penable/pready  os_running at byte address 0
//
// create, delay, interrupt enter/exit and schedule: item passes the exec and finish states, result registered in finish
// tick: the sweep reads one delay counter per cycle and decrements live ones through a shared write port
// no new transfer is taken while an item is in work; a held result stalls the next item
// in its finish state, which then keeps the input stalled until the result is taken
// reset clears all control and scheduling state; the delay memory needs no clearing pass
module priority_task_scheduler #(
  parameter int LOWEST_PRIORITY = pts_pkg::LOWEST_PRIO_DEF,
  parameter int TASK_SLOTS      = pts_pkg::TASK_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pts_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pts_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pts_pkg::*;

  localparam int NP = LOWEST_PRIORITY + 1;
  localparam int PW = $clog2(NP);
  localparam logic [PRIO_W-1:0] LowPrio   = PRIO_W'(LOWEST_PRIORITY);
  localparam logic [SLOT_W-1:0] SlotLimit = SLOT_W'(TASK_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state_q;
  in_item_t            in_q;
  logic [2:0]          status_q;
  logic                sched_q;
  logic [NUM_PRIO-1:0] ready_q;
  logic [NP-1:0]       occ_q;
  logic [NP-1:0]       sleep_q;
  logic [SLOT_W-1:0]   slots_q;
  logic [ISR_W-1:0]    isr_q;
  logic [PRIO_W-1:0]   cur_q;
  logic [TICK_W-1:0]   tick_q;
  logic                os_running_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic [7:0]          group;
  logic [2:0]          best_y;
  logic [2:0]          best_x;
  logic [PRIO_W-1:0]   best;
  logic                out_free;
  logic                sw;
  logic [2:0]          create_st;
  logic                delay_ok;
  logic                cfg_wr;
  sweep_cmd_t          cmd;
  sweep_rpt_t          rpt;

  // group bit set when its row holds a ready task
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      group[g] = |ready_q[g*8 +: 8];
    end
  end

  assign best_y = low_bit(group);
  assign best_x = low_bit(ready_q[{best_y, 3'b000} +: 8]);
  assign best   = {best_y, best_x};

  assign out_free = !out_valid_q || !out_stall_i;
  assign sw       = sched_q && (best != cur_q);

  always_comb begin
    if (in_q.priority_req == '0 || in_q.priority_req > LowPrio) create_st = ST_BAD_PRIO;
    else if (occ_q[in_q.priority_req[PW-1:0]])                 create_st = ST_TAKEN;
    else if (isr_q != '0)                                       create_st = ST_IN_ISR;
    else if (slots_q >= SlotLimit)                              create_st = ST_NO_SLOT;
    else                                                        create_st = ST_OK;
  end

  assign delay_ok = (isr_q == '0) && (in_q.delay_ticks != '0) && occ_q[cur_q[PW-1:0]];

  always_comb begin
    cmd.load  = 1'b0;
    cmd.start = 1'b0;
    cmd.addr  = in_q.priority_req;
    cmd.value = '0;
    if (state_q == S_EXEC) begin
      case (in_q.operation)
        OP_CREATE: cmd.load = (create_st == ST_OK);
        OP_DELAY: begin
          cmd.load  = delay_ok;
          cmd.addr  = cur_q;
          cmd.value = in_q.delay_ticks;
        end
        OP_TICK:  cmd.start = 1'b1;
        default:  cmd.load  = 1'b0;
      endcase
    end
  end

  pts_sweep #(
    .NP(NP)
  ) u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .occupied_i (occ_q),
    .rpt_o      (rpt)
  );

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      status_q     <= ST_OK;
      sched_q      <= 1'b0;
      ready_q      <= '0;
      occ_q        <= '0;
      sleep_q      <= '0;
      slots_q      <= '0;
      isr_q        <= '0;
      cur_q        <= '0;
      tick_q       <= '0;
      os_running_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) os_running_q <= pwdata[0];
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          status_q <= ST_OK;
          sched_q  <= 1'b0;
          state_q  <= S_FIN;
          case (in_q.operation)
            OP_CREATE: begin
              status_q <= create_st;
              if (create_st == ST_OK) begin
                occ_q[in_q.priority_req[PW-1:0]]   <= 1'b1;
                sleep_q[in_q.priority_req[PW-1:0]] <= 1'b0;
                slots_q                            <= slots_q + SLOT_W'(1);
                ready_q[in_q.priority_req]         <= 1'b1;
              end
            end
            OP_DELAY: begin
              if (delay_ok) begin
                ready_q[cur_q]          <= 1'b0;
                sleep_q[cur_q[PW-1:0]] <= 1'b1;
                sched_q                 <= 1'b1;
              end else begin
                status_q <= ST_IGNORED;
              end
            end
            OP_TICK: begin
              tick_q  <= tick_q + TICK_W'(1);
              state_q <= S_TICK;
            end
            OP_ISR_ENTER: isr_q <= isr_q + ISR_W'(1);
            OP_ISR_EXIT: begin
              if (!os_running_q || isr_q == '0) begin
                status_q <= ST_IGNORED;
              end else begin
                isr_q   <= isr_q - ISR_W'(1);
                sched_q <= (isr_q == ISR_W'(1));
              end
            end
            OP_SCHEDULE: begin
              if (isr_q != '0) status_q <= ST_IGNORED;
              else             sched_q  <= 1'b1;
            end
            default: status_q <= ST_IGNORED;
          endcase
        end
        S_TICK: begin
          // sleeper whose counter hit zero goes back on the ready list
          if (rpt.expired && sleep_q[rpt.idx[PW-1:0]]) begin
            sleep_q[rpt.idx[PW-1:0]] <= 1'b0;
            ready_q[rpt.idx]         <= 1'b1;
          end
          if (rpt.done) state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (sw) cur_q <= best;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) in_q <= in_data_i;
    if (state_q == S_FIN && out_free) begin
      out_q.status         <= status_q;
      out_q.switch_request <= sw;
      out_q.next_priority  <= best;
      out_q.tick_count     <= tick_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == 1'b0) ? {31'd0, os_running_q} : 32'd0;

endmodule

// File: hdl/pts_sweep.sv
// delay counter memory with a shared decrement unit that sweeps all entries on a tick
// depends on pts_pkg
module pts_sweep #(
  parameter int NP = pts_pkg::LOWEST_PRIO_DEF + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pts_pkg::sweep_cmd_t cmd_i,
  input  logic [NP-1:0]       occupied_i,
  output pts_pkg::sweep_rpt_t rpt_o
);
  import pts_pkg::*;

  localparam int PW = (NP > 1) ? $clog2(NP) : 1;
  localparam int CW = PW + 1;
  localparam logic [CW-1:0] LastCnt = CW'(NP);
  localparam logic [PW-1:0] LastIdx = PW'(NP - 1);

  logic [TICK_W-1:0] mem [NP];
  logic [TICK_W-1:0] rdata_q;
  logic [CW-1:0]     rd_cnt_q, rd_cnt_d;
  logic              issue_q, issue_d;
  logic              s1_valid_q, s1_valid_d;
  logic [PW-1:0]     s1_idx_q, s1_idx_d;

  logic              wr_en;
  logic [PW-1:0]     wr_addr;
  logic [TICK_W-1:0] wr_data;
  logic              live;
  logic [TICK_W-1:0] dec;

  assign live = occupied_i[s1_idx_q] && (rdata_q != '0);
  assign dec  = rdata_q - TICK_W'(1);

  always_comb begin
    rd_cnt_d   = rd_cnt_q;
    issue_d    = issue_q;
    s1_valid_d = 1'b0;
    s1_idx_d   = s1_idx_q;
    if (cmd_i.start) begin
      rd_cnt_d = '0;
      issue_d  = 1'b1;
    end else if (issue_q) begin
      s1_valid_d = 1'b1;
      s1_idx_d   = rd_cnt_q[PW-1:0];
      rd_cnt_d   = rd_cnt_q + CW'(1);
      if (rd_cnt_q + CW'(1) == LastCnt) issue_d = 1'b0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd_i.addr[PW-1:0];
    wr_data = cmd_i.value;
    if (s1_valid_q && live) begin
      wr_en   = 1'b1;
      wr_addr = s1_idx_q;
      wr_data = dec;
    end else if (cmd_i.load) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q   <= '0;
      issue_q    <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_idx_q   <= '0;
    end else begin
      rd_cnt_q   <= rd_cnt_d;
      issue_q    <= issue_d;
      s1_valid_q <= s1_valid_d;
      s1_idx_q   <= s1_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_q <= mem[rd_cnt_q[PW-1:0]];
  end

  assign rpt_o.expired = s1_valid_q && live && (rdata_q == TICK_W'(1));
  assign rpt_o.idx     = PRIO_W'(s1_idx_q);
  assign rpt_o.done    = s1_valid_q && (s1_idx_q == LastIdx);

endmodule
